// ----- sv/pfde_pkg.sv -----
// Shared types and constants for the page framebuffer draw engine.
`default_nettype none
package pfde_pkg;
    localparam int PageRows   = 8;
    localparam int GlyphBits  = 40;

    typedef enum logic [3:0] {
        ACT_SET_PX   = 4'd0,
        ACT_CLR_PX   = 4'd1,
        ACT_GET_PX   = 4'd2,
        ACT_FILL     = 4'd3,
        ACT_CLR_RECT = 4'd4,
        ACT_INVERT   = 4'd5,
        ACT_OUTLINE  = 4'd6,
        ACT_GLYPH    = 4'd7,
        ACT_READ     = 4'd8
    } t_action;

    // Byte operation applied by the back end to one page byte.
    typedef enum logic [1:0] {
        OP_OR  = 2'd0,
        OP_AND = 2'd1,
        OP_XOR = 2'd2,
        OP_RD  = 2'd3
    } t_op;

    // One byte job: a single read-modify-write of one page byte.
    typedef struct packed {
        t_op        op;
        logic [4:0] page;
        logic [7:0] col;
        logic [7:0] mask;
        logic [2:0] sel;
        logic       ret;
        logic       last;
    } t_job;
endpackage
`default_nettype wire

// ----- sv/pfde_front.sv -----
// Front end: walks each command into a sequence of page byte jobs.
`default_nettype none
module pfde_front #(
    parameter int DISPLAY_WIDTH = 128,
    parameter int DISPLAY_PAGES = 8,
    parameter int GLYPH_COLUMNS = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [3:0]    i_action,
    input  wire logic [7:0]    i_pos_x,
    input  wire logic [7:0]    i_pos_y,
    input  wire logic [7:0]    i_rect_width,
    input  wire logic [7:0]    i_rect_height,
    input  wire logic [39:0]   i_glyph_bits,
    input  wire logic          i_full,
    output logic               o_busy,
    output logic               o_push,
    output pfde_pkg::t_job     o_job
);
    import pfde_pkg::*;

    localparam int DispRows = DISPLAY_PAGES * PageRows;

    typedef enum logic [1:0] {S_IDLE, S_RECT, S_OUTL, S_GLYPH} t_state;

    t_state      r_state;
    logic [3:0]  r_act;
    logic [8:0]  r_x0, r_x1, r_y0, r_y1;   // inclusive clipped bounds
    logic [8:0]  r_col;
    logic [5:0]  r_pg;
    logic [8:0]  r_ox1, r_oy1;            // unclipped far edges of the outline
    logic [7:0]  r_y;
    logic [39:0] r_bits;
    logic [3:0]  r_gi;
    logic        r_hi;

    // Mask of rows lo..hi inside page pg, both as absolute display row numbers.
    function automatic logic [7:0] row_mask(input logic [8:0] lo, input logic [8:0] hi,
                                            input logic [5:0] pg);
        logic [7:0] m;
        logic [8:0] r;
        m = '0;
        for (int k = 0; k < 8; k++) begin
            r = {pg, 3'(k)};
            m[k] = (r >= lo) && (r <= hi);
        end
        return m;
    endfunction

    logic        push;
    t_job        job;
    logic [8:0]  xe, ye;
    logic        rect_ok;
    logic [7:0]  gb;
    logic [15:0] gsh;

    always_comb begin
        xe = 9'(i_pos_x) + 9'(i_rect_width) - 9'd1;
        ye = 9'(i_pos_y) + 9'(i_rect_height) - 9'd1;
        rect_ok = (i_rect_width != 0) && (i_rect_height != 0)
                  && (9'(i_pos_x) < 9'(DISPLAY_WIDTH)) && (9'(i_pos_y) < 9'(DispRows));
        gb  = r_bits[7:0];
        gsh = 16'(gb) << r_y[2:0];
        push = 1'b0;
        job  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start && !i_full) begin
                    push = 1'b1;
                    job.last = 1'b1;
                    job.col  = i_pos_x;
                    job.page = 5'(i_pos_y >> 3);
                    job.sel  = i_pos_y[2:0];
                    case (i_action)
                        ACT_SET_PX, ACT_CLR_PX, ACT_GET_PX: begin
                            if (i_pos_x < 8'(DISPLAY_WIDTH) && 9'(i_pos_y) < 9'(DispRows)) begin
                                job.mask = 8'd1 << i_pos_y[2:0];
                            end
                            job.op  = (i_action == ACT_SET_PX) ? OP_OR :
                                      (i_action == ACT_CLR_PX) ? OP_AND : OP_RD;
                            job.ret = (i_action == ACT_GET_PX);
                        end
                        ACT_READ: begin
                            job.op = OP_RD;
                            job.page = 5'(i_pos_y);
                            job.sel = 3'd0;
                            job.ret = 1'b1;
                            if (i_pos_x < 8'(DISPLAY_WIDTH) && i_pos_y < 8'(DISPLAY_PAGES)) begin
                                job.mask = 8'hFF;
                            end
                        end
                        ACT_FILL, ACT_CLR_RECT, ACT_INVERT, ACT_OUTLINE: begin
                            // An empty or off-display rectangle still gives its word.
                            job.op = OP_RD;
                            push = !rect_ok;
                        end
                        ACT_GLYPH: begin
                            job.op = OP_RD;
                            push = (9'(i_pos_x) >= 9'(DISPLAY_WIDTH));
                        end
                        default: job.op = OP_RD;
                    endcase
                end
            end
            S_RECT, S_OUTL: begin
                if (!i_full) begin
                    push = 1'b1;
                    job.col  = r_col[7:0];
                    job.page = r_pg[4:0];
                    job.op   = (r_act == ACT_CLR_RECT) ? OP_AND :
                               (r_act == ACT_INVERT) ? OP_XOR : OP_OR;
                    if (r_state == S_RECT || r_col == r_x0[8:0] || r_col == r_ox1) begin
                        job.mask = row_mask(r_y0, r_y1, r_pg);
                    end else begin
                        job.mask = row_mask(r_y0, r_y0, r_pg) | row_mask(r_oy1, r_oy1, r_pg);
                    end
                    job.last = (r_col == r_x1) && ({3'd0, r_pg} == (r_y1 >> 3));
                end
            end
            S_GLYPH: begin
                if (!i_full) begin
                    push = 1'b1;
                    job.op   = OP_OR;
                    job.col  = r_col[7:0];
                    job.page = 5'((r_y >> 3) + 8'(r_hi));
                    job.mask = r_hi ? gsh[15:8] : gsh[7:0];
                    if (9'(job.page) >= 9'(DISPLAY_PAGES) || (r_hi && r_y[7:3] == 5'd31)) begin
                        job.mask = '0;
                    end
                    job.last = (r_hi || r_y[2:0] == 0)
                               && ((r_gi == 4'(GLYPH_COLUMNS - 1))
                                   || (r_col == 9'(DISPLAY_WIDTH - 1)));
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start && !i_full) begin
                        r_act  <= i_action;
                        r_x0   <= 9'(i_pos_x);
                        r_y0   <= 9'(i_pos_y);
                        r_ox1  <= xe;
                        r_oy1  <= ye;
                        r_x1   <= (xe >= 9'(DISPLAY_WIDTH)) ? 9'(DISPLAY_WIDTH - 1) : xe;
                        r_y1   <= (ye >= 9'(DispRows)) ? 9'(DispRows - 1) : ye;
                        r_col  <= 9'(i_pos_x);
                        r_pg   <= 6'(i_pos_y >> 3);
                        r_y    <= i_pos_y;
                        r_bits <= i_glyph_bits;
                        r_gi   <= '0;
                        r_hi   <= 1'b0;
                        case (i_action)
                            ACT_FILL, ACT_CLR_RECT, ACT_INVERT:
                                r_state <= rect_ok ? S_RECT : S_IDLE;
                            ACT_OUTLINE:
                                r_state <= rect_ok ? S_OUTL : S_IDLE;
                            ACT_GLYPH:
                                r_state <= (9'(i_pos_x) < 9'(DISPLAY_WIDTH)) ? S_GLYPH : S_IDLE;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_RECT, S_OUTL: begin
                    if (push) begin
                        if (job.last) begin
                            r_state <= S_IDLE;
                        end else if ({3'd0, r_pg} == (r_y1 >> 3)) begin
                            r_pg  <= 6'(r_y0 >> 3);
                            r_col <= r_col + 9'd1;
                        end else begin
                            r_pg <= r_pg + 6'd1;
                        end
                    end
                end
                S_GLYPH: begin
                    if (push) begin
                        if (job.last) begin
                            r_state <= S_IDLE;
                        end else if (r_hi || r_y[2:0] == 0) begin
                            r_hi   <= 1'b0;
                            r_col  <= r_col + 9'd1;
                            r_gi   <= r_gi + 4'd1;
                            r_bits <= {8'd0, r_bits[39:8]};
                        end else begin
                            r_hi <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE) || i_full;
    assign o_push = push;
    assign o_job  = job;
endmodule
`default_nettype wire

// ----- sv/pfde_back.sv -----
// Back end: job queue, page memory with clearing pass, read-modify-write.
`default_nettype none
module pfde_back #(
    parameter int DISPLAY_WIDTH = 128,
    parameter int DISPLAY_PAGES = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  pfde_pkg::t_job  i_job,
    output logic            o_full,
    output logic            o_valid,
    output logic [7:0]      o_read_value
);
    import pfde_pkg::*;

    localparam int Depth = DISPLAY_WIDTH * DISPLAY_PAGES;
    localparam int AW    = $clog2(Depth);

    // Two-entry queue.
    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [7:0] r_mem [Depth];

    // Stage 1 holds the job whose byte is being read.
    logic       r_s1v;
    t_job       r_s1;
    logic [7:0] r_rd;
    logic [AW:0] r_clr;
    logic       clearing, pop, wr_en, hazard;
    logic [AW-1:0] rd_addr, s1_addr, clr_addr;
    logic [7:0] cur, newb;
    t_job       head;

    function automatic logic [AW-1:0] addr_of(input t_job j);
        return AW'(32'(j.page) * DISPLAY_WIDTH + 32'(j.col));
    endfunction

    always_comb begin
        clearing = (r_clr != (AW+1)'(Depth));
        clr_addr = r_clr[AW-1:0];
        head     = r_q[r_rp];
        rd_addr  = addr_of(head);
        s1_addr  = addr_of(r_s1);
        // Hold the next job back when it touches the byte being written.
        hazard   = r_s1v && (r_s1.op != OP_RD) && (s1_addr == rd_addr);
        pop      = (r_cnt != 0) && !clearing && !hazard;
        cur      = r_rd;
        case (r_s1.op)
            OP_OR:   newb = cur | r_s1.mask;
            OP_AND:  newb = cur & ~r_s1.mask;
            OP_XOR:  newb = cur ^ r_s1.mask;
            default: newb = cur;
        endcase
        wr_en = r_s1v && (r_s1.op != OP_RD) && (r_s1.mask != 0);
    end

    assign o_full = (r_cnt == 2'd2) || clearing;

    always_ff @(posedge i_clk) begin
        if (clearing) begin
            r_mem[clr_addr] <= '0;
        end else if (wr_en) begin
            r_mem[s1_addr] <= newb;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
            r_s1v <= 1'b0;
            r_clr <= '0;
            o_valid <= 1'b0;
        end else begin
            if (clearing) begin
                r_clr <= r_clr + (AW+1)'(1);
            end
            if (i_push) begin
                r_q[r_wp] <= i_job;
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
                r_s1 <= head;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
            r_s1v <= pop;
            o_valid <= r_s1v && r_s1.last;
            if (r_s1v && r_s1.last) begin
                if (!r_s1.ret || r_s1.mask == 0) begin
                    o_read_value <= '0;
                end else if (r_s1.op == OP_RD && r_s1.mask == 8'hFF) begin
                    o_read_value <= cur;
                end else begin
                    o_read_value <= {7'd0, cur[r_s1.sel]};
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/page_framebuffer_draw_engine.sv -----
// Top level of the page framebuffer draw engine.
// With the job queue empty, point and read commands pass through the job queue
// and the read stage before o_done and o_read_value are registered; up to one
// command per cycle while the queue has room, and a job that touches the byte just
// written is held back. Rectangles give one job per touched page byte, glyphs one
// or two per column. After reset busy stays high while the page memory is cleared.
`default_nettype none
module page_framebuffer_draw_engine #(
    parameter int DISPLAY_WIDTH = 128,
    parameter int DISPLAY_PAGES = 8,
    parameter int GLYPH_COLUMNS = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  i_action,
    input  wire logic [7:0]  i_pos_x,
    input  wire logic [7:0]  i_pos_y,
    input  wire logic [7:0]  i_rect_width,
    input  wire logic [7:0]  i_rect_height,
    input  wire logic [39:0] i_glyph_bits,
    output logic             o_done,
    output logic [7:0]       o_read_value
);
    import pfde_pkg::*;

    logic full, push;
    t_job job;

    pfde_front #(.DISPLAY_WIDTH(DISPLAY_WIDTH), .DISPLAY_PAGES(DISPLAY_PAGES),
                 .GLYPH_COLUMNS(GLYPH_COLUMNS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_action(i_action), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_rect_width(i_rect_width), .i_rect_height(i_rect_height),
        .i_glyph_bits(i_glyph_bits), .i_full(full),
        .o_busy(busy), .o_push(push), .o_job(job)
    );

    pfde_back #(.DISPLAY_WIDTH(DISPLAY_WIDTH), .DISPLAY_PAGES(DISPLAY_PAGES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(job),
        .o_full(full), .o_valid(o_done), .o_read_value(o_read_value)
    );
endmodule
`default_nettype wire

// ----- sv/pfde_checker.sv -----
// Port-level checks for the page framebuffer draw engine.
`default_nettype none
module pfde_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       busy,
    input wire logic       o_done,
    input wire logic [7:0] o_read_value
);
    a_busy_reset: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low straight after reset");
    a_done_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result strobe straight after reset");
    a_busy_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(busy))
        else $error("busy unknown");
    a_value_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown(o_read_value))
        else $error("result value unknown");
endmodule

bind page_framebuffer_draw_engine pfde_checker u_pfde_checker (.*);
`default_nettype wire

// ----- verif/page_framebuffer_draw_engine_tb.sv -----
// Self-checking testbench for the page framebuffer draw engine.
`timescale 1ns / 1ps
module page_framebuffer_draw_engine_tb;
    import pfde_pkg::*;

    localparam int Width = 128;
    localparam int Pages = 8;
    localparam int Rows  = Pages * PageRows;
    localparam int Cols  = 5;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  i_action = '0;
    logic [7:0]  i_pos_x = '0;
    logic [7:0]  i_pos_y = '0;
    logic [7:0]  i_rect_width = '0;
    logic [7:0]  i_rect_height = '0;
    logic [39:0] i_glyph_bits = '0;
    logic        o_done;
    logic [7:0]  o_read_value;

    logic [7:0] shadow_frame [Width*Pages] = '{default: 8'd0};
    logic [7:0] pending_reads [$];
    int         error_count = 0;

    page_framebuffer_draw_engine #(
        .DISPLAY_WIDTH(Width), .DISPLAY_PAGES(Pages), .GLYPH_COLUMNS(Cols)
    ) dut (.*);

    always #6 i_clk = ~i_clk;

    // op: 0 clear, 1 set, 2 invert.
    function automatic void paint_pixel(int x, int y, int op);
        int idx;
        logic [7:0] m;
        if (x < 0 || x >= Width || y < 0 || y >= Rows) return;
        idx = (y / PageRows) * Width + x;
        m = 8'd1 << (y % PageRows);
        if (op == 1) shadow_frame[idx] |= m;
        else if (op == 0) shadow_frame[idx] &= ~m;
        else shadow_frame[idx] ^= m;
    endfunction

    function automatic logic [7:0] apply_command(logic [3:0] a, int x, int y, int w, int h,
                                                 logic [39:0] g);
        logic [7:0] r;
        int pg, off, cx, idx;
        logic [7:0] b;
        logic [15:0] sh;
        r = '0;
        case (a)
            ACT_SET_PX: paint_pixel(x, y, 1);
            ACT_CLR_PX: paint_pixel(x, y, 0);
            ACT_GET_PX:
                if (x < Width && y < Rows)
                    r = {7'd0, shadow_frame[(y / PageRows) * Width + x][y % PageRows]};
            ACT_FILL, ACT_CLR_RECT, ACT_INVERT:
                for (int j = 0; j < h; j++)
                    for (int i = 0; i < w; i++)
                        paint_pixel(x + i, y + j,
                                    a == ACT_FILL ? 1 : (a == ACT_CLR_RECT ? 0 : 2));
            ACT_OUTLINE:
                if (w != 0 && h != 0) begin
                    for (int i = 0; i < w; i++) begin
                        paint_pixel(x + i, y, 1);
                        paint_pixel(x + i, y + h - 1, 1);
                    end
                    for (int i = 0; i < h; i++) begin
                        paint_pixel(x, y + i, 1);
                        paint_pixel(x + w - 1, y + i, 1);
                    end
                end
            ACT_GLYPH: begin
                pg = y / PageRows;
                off = y % PageRows;
                for (int c = 0; c < Cols; c++) begin
                    cx = x + c;
                    if (cx >= Width) break;
                    b = (c * 8 < GlyphBits) ? g[c*8 +: 8] : 8'd0;
                    sh = {8'd0, b} << off;
                    if (pg < Pages) begin
                        idx = pg * Width + cx;
                        shadow_frame[idx] |= sh[7:0];
                    end
                    if (off != 0 && pg + 1 < Pages) begin
                        idx = (pg + 1) * Width + cx;
                        shadow_frame[idx] |= sh[15:8];
                    end
                end
            end
            ACT_READ:
                if (x < Width && y < Pages) r = shadow_frame[y * Width + x];
            default: ;
        endcase
        return r;
    endfunction

    // Start only falls when a gap is actually inserted, so it never gets two
    // assignments at one edge.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n != 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_command(logic [3:0] a, logic [7:0] x, logic [7:0] y,
                                logic [7:0] w, logic [7:0] h, logic [39:0] g);
        idle_gap();
        start <= 1'b1;
        i_action <= a;
        i_pos_x <= x;
        i_pos_y <= y;
        i_rect_width <= w;
        i_rect_height <= h;
        i_glyph_bits <= g;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_reads.push_back(apply_command(a, int'(x), int'(y), int'(w), int'(h), g));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_reads.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $time, o_read_value);
                error_count++;
            end else begin
                if (o_read_value !== pending_reads[0]) begin
                    $display("%0t: read_value expected %h actual %h", $time,
                             pending_reads[0], o_read_value);
                    error_count++;
                end
                void'(pending_reads.pop_front());
            end
        end
    end

    task automatic drain();
        start <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_points();
        send_command(ACT_SET_PX, 0, 0, 0, 0, 0);
        send_command(ACT_SET_PX, 127, 63, 0, 0, 0);
        send_command(ACT_GET_PX, 127, 63, 0, 0, 0);
        send_command(ACT_GET_PX, 255, 255, 0, 0, 0);
        send_command(ACT_SET_PX, 128, 64, 0, 0, 0);
        send_command(ACT_CLR_PX, 0, 0, 0, 0, 0);
        send_command(ACT_GET_PX, 0, 0, 0, 0, 0);
        send_command(ACT_READ, 127, 7, 0, 0, 0);
        send_command(ACT_READ, 255, 255, 0, 0, 0);
        send_command(4'd15, 255, 255, 255, 255, '1);
    endtask

    task automatic test_rectangles();
        send_command(ACT_FILL, 10, 3, 0, 9, 0);
        send_command(ACT_FILL, 10, 3, 9, 0, 0);
        send_command(ACT_FILL, 120, 60, 255, 255, 0);
        send_command(ACT_INVERT, 0, 0, 20, 20, 0);
        send_command(ACT_CLR_RECT, 5, 5, 7, 7, 0);
        send_command(ACT_OUTLINE, 30, 30, 1, 1, 0);
        send_command(ACT_OUTLINE, 40, 10, 1, 12, 0);
        send_command(ACT_OUTLINE, 100, 50, 60, 30, 0);
        send_command(ACT_GLYPH, 125, 3, 0, 0, '1);
        send_command(ACT_GLYPH, 0, 60, 0, 0, 40'h55aa_ff01_80);
        send_command(ACT_GLYPH, 200, 255, 0, 0, '1);
        for (int i = 0; i < 6; i++)
            send_command(ACT_READ, 8'(125 + i % 3), 8'(7 - i), 0, 0, 0);
    endtask

    task automatic test_random(int n);
        int r;
        logic [3:0] a;
        logic [7:0] x, y, w, h;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 19);
            a = (r == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
            // Mostly on-screen coordinates with small rectangles; some wild.
            if ($urandom_range(0, 7) == 0) begin
                x = 8'($urandom); y = 8'($urandom); w = 8'($urandom); h = 8'($urandom);
            end else begin
                x = 8'($urandom_range(0, Width - 1));
                y = (a == ACT_READ) ? 8'($urandom_range(0, Pages - 1))
                                    : 8'($urandom_range(0, Rows - 1));
                w = 8'($urandom_range(0, 12));
                h = 8'($urandom_range(0, 12));
            end
            send_command(a, x, y, w, h, 40'({$urandom, $urandom}));
            if (k == n / 2) drain();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_points();
        test_rectangles();
        test_random(1850);
        drain();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_reads.size() == 0)
            $display("page_framebuffer_draw_engine_tb passed");
        else
            $display("page_framebuffer_draw_engine_tb failed");
        $finish;
    end

    initial begin
        #200ms;
        $display("page_framebuffer_draw_engine_tb failed");
        $finish;
    end
endmodule

// ----- page_framebuffer_draw_engine.f -----
sv/pfde_pkg.sv
sv/pfde_front.sv
sv/pfde_back.sv
sv/page_framebuffer_draw_engine.sv
sv/pfde_checker.sv
verif/page_framebuffer_draw_engine_tb.sv
